FILE: hdl/lpsp_pkg.sv
// Package for the length-prefixed string parser.
// Holds widths, phase codes, character constants and the state/result structs.
// No dependencies.
package lpsp_pkg;

   localparam int COUNT_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int CAP_WIDTH   = 16;
   localparam int MUL_WIDTH   = COUNT_WIDTH + 4;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CAP_WIDTH) ? COUNT_WIDTH : CAP_WIDTH;

   localparam logic [CAP_WIDTH-1:0]   CAPACITY_RESET = {CAP_WIDTH{1'b1}};
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX      = {COUNT_WIDTH{1'b1}};

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [2:0] PHASE_CODE_START   = 3'd0;
   localparam logic [2:0] PHASE_CODE_LENGTH  = 3'd1;
   localparam logic [2:0] PHASE_CODE_PAYLOAD = 3'd2;
   localparam logic [2:0] PHASE_CODE_DONE    = 3'd3;
   localparam logic [2:0] PHASE_CODE_ERROR   = 3'd4;

   typedef enum logic [4:0] {
      PH_START   = 5'b00001,
      PH_LENGTH  = 5'b00010,
      PH_PAYLOAD = 5'b00100,
      PH_DONE    = 5'b01000,
      PH_ERROR   = 5'b10000
   } phase_type;

   typedef struct packed {
      phase_type              phase;
      logic [COUNT_WIDTH-1:0] length_value;
      logic [COUNT_WIDTH-1:0] byte_count;
   } parse_state_type;

   typedef struct packed {
      logic [2:0]           phase;
      logic                 rejected;
      logic                 data_valid;
      logic [7:0]           data_byte;
      logic [OUT_WIDTH-1:0] data_index;
      logic                 overflow;
      logic [OUT_WIDTH-1:0] declared_size;
      logic [OUT_WIDTH-1:0] received_count;
      logic                 is_done;
   } result_type;

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] code;
      case (ph)
         PH_START:   code = PHASE_CODE_START;
         PH_LENGTH:  code = PHASE_CODE_LENGTH;
         PH_PAYLOAD: code = PHASE_CODE_PAYLOAD;
         PH_DONE:    code = PHASE_CODE_DONE;
         default:    code = PHASE_CODE_ERROR;
      endcase
      return code;
   endfunction

endpackage

FILE: hdl/length_prefixed_string_parser.sv
// Top level of the length-prefixed string parser: handshakes, state and result registers.
// Depends on lpsp_pkg and lpsp_step.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid/req_ready    in_byte, chunk_end
//   rsp_      out        rsp_valid/rsp_ready    phase .. is_done (one result per byte)
//   csr_      in         csr_wr_en              capacity (16 bits)
//
// One byte per cycle unless rsp_ready stalls; result is valid the cycle after transfer.
// The parse state and result register update in the same cycle as the transfer.
// A new byte is taken whenever the result register is empty or being drained.
// Synchronous reset clears phase, length, count, rsp_valid; capacity returns to 65535.
module length_prefixed_string_parser (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [7:0]                          req_in_byte,
   input  logic                                req_chunk_end,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [2:0]                          rsp_phase,
   output logic                                rsp_rejected,
   output logic                                rsp_data_valid,
   output logic [7:0]                          rsp_data_byte,
   output logic [lpsp_pkg::OUT_WIDTH-1:0]      rsp_data_index,
   output logic                                rsp_overflow,
   output logic [lpsp_pkg::OUT_WIDTH-1:0]      rsp_declared_size,
   output logic [lpsp_pkg::OUT_WIDTH-1:0]      rsp_received_count,
   output logic                                rsp_is_done,
   input  logic                                csr_wr_en,
   input  logic [lpsp_pkg::CAP_WIDTH-1:0]      csr_wr_data
);

   lpsp_pkg::parse_state_type           state_ff;
   lpsp_pkg::parse_state_type           state_in;
   lpsp_pkg::result_type                result_ff;
   lpsp_pkg::result_type                result_in;
   logic                                rsp_valid_ff;
   logic [lpsp_pkg::CAP_WIDTH-1:0]      capacity_ff;
   logic                                req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   lpsp_step u_step (
      .state_cur (state_ff),
      .in_byte   (req_in_byte),
      .capacity  (capacity_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase        <= lpsp_pkg::PH_START;
         state_ff.length_value <= '0;
         state_ff.byte_count   <= '0;
         rsp_valid_ff          <= 1'b0;
         capacity_ff           <= lpsp_pkg::CAPACITY_RESET;
      end else begin
         if (csr_wr_en) begin
            capacity_ff <= csr_wr_data;
         end
         if (req_xfer) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_phase          = result_ff.phase;
   assign rsp_rejected       = result_ff.rejected;
   assign rsp_data_valid     = result_ff.data_valid;
   assign rsp_data_byte      = result_ff.data_byte;
   assign rsp_data_index     = result_ff.data_index;
   assign rsp_overflow       = result_ff.overflow;
   assign rsp_declared_size  = result_ff.declared_size;
   assign rsp_received_count = result_ff.received_count;
   assign rsp_is_done        = result_ff.is_done;

endmodule

FILE: hdl/lpsp_step.sv
// Next-state and result logic for one byte of the length-prefixed string parser.
// Depends on lpsp_pkg.
module lpsp_step (
   input  lpsp_pkg::parse_state_type         state_cur,
   input  logic [7:0]                        in_byte,
   input  logic [lpsp_pkg::CAP_WIDTH-1:0]    capacity,
   output lpsp_pkg::parse_state_type         state_nxt,
   output lpsp_pkg::result_type              result
);

   logic [lpsp_pkg::MUL_WIDTH-1:0]   len_ext;
   logic [lpsp_pkg::MUL_WIDTH-1:0]   len_scaled;
   logic [lpsp_pkg::MUL_WIDTH-1:0]   digit_ext;
   logic                             is_digit;
   logic                             over_cap;
   logic                             payload_end;

   assign is_digit  = (in_byte >= lpsp_pkg::CHAR_ZERO) && (in_byte <= lpsp_pkg::CHAR_NINE);
   assign len_ext   = lpsp_pkg::MUL_WIDTH'(state_cur.length_value);
   assign digit_ext = lpsp_pkg::MUL_WIDTH'(in_byte - lpsp_pkg::CHAR_ZERO);
   assign len_scaled = (len_ext << 3) + (len_ext << 1) + digit_ext;
   assign over_cap = lpsp_pkg::CMP_WIDTH'(state_cur.byte_count)
                     >= lpsp_pkg::CMP_WIDTH'(capacity);
   assign payload_end = state_cur.byte_count >= state_cur.length_value;

   always_comb begin
      state_nxt         = state_cur;
      result.rejected   = 1'b0;
      result.data_valid = 1'b0;
      result.data_byte  = 8'd0;
      result.data_index = '0;
      result.overflow   = 1'b0;
      case (state_cur.phase)
         lpsp_pkg::PH_START: begin
            if (in_byte == lpsp_pkg::CHAR_DOLLAR) begin
               state_nxt.phase = lpsp_pkg::PH_LENGTH;
            end else begin
               state_nxt.phase = lpsp_pkg::PH_ERROR;
               result.rejected = 1'b1;
            end
         end
         lpsp_pkg::PH_LENGTH: begin
            if (in_byte == lpsp_pkg::CHAR_LF) begin
               state_nxt.phase = lpsp_pkg::PH_PAYLOAD;
            end else if (is_digit) begin
               if (len_scaled > lpsp_pkg::MUL_WIDTH'(lpsp_pkg::COUNT_MAX)) begin
                  state_nxt.length_value = lpsp_pkg::COUNT_MAX;
               end else begin
                  state_nxt.length_value = len_scaled[lpsp_pkg::COUNT_WIDTH-1:0];
               end
            end
         end
         lpsp_pkg::PH_PAYLOAD: begin
            if (payload_end) begin
               state_nxt.phase = lpsp_pkg::PH_DONE;
            end else begin
               result.data_byte     = in_byte;
               result.data_index    = lpsp_pkg::OUT_WIDTH'(state_cur.byte_count);
               result.overflow      = over_cap;
               result.data_valid    = !over_cap;
               state_nxt.byte_count = state_cur.byte_count + 1'b1;
            end
         end
         default: begin
         end
      endcase
      result.phase          = lpsp_pkg::phase_code(state_nxt.phase);
      result.declared_size  = lpsp_pkg::OUT_WIDTH'(state_nxt.length_value);
      result.received_count = lpsp_pkg::OUT_WIDTH'(state_nxt.byte_count);
      result.is_done        = state_nxt.phase == lpsp_pkg::PH_DONE;
   end

endmodule
